// ----- src/jsq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package jsq_pkg;

    localparam int PORTS          = 2;
    localparam int BYTES_PER_PORT = 12;
    localparam int MEM_DEPTH      = PORTS * BYTES_PER_PORT;
    localparam int MEM_AW         = $clog2(MEM_DEPTH);

    localparam logic [3:0] SLOT_END   = 4'd13;
    localparam logic [3:0] SLOT_LAST  = 4'd12;
    localparam logic [7:0] LATENCY    = 8'd3;
    localparam logic [7:0] BYTE_IDLE  = 8'hff;
    localparam logic [MEM_AW-1:0] PORT1_BASE = MEM_AW'(BYTES_PER_PORT);

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LOAD  = 2'd2
    } cmd_t;

    localparam logic [2:0] PAD_TWO_BUTTON = 3'd0;
    localparam logic [2:0] PAD_MD         = 3'd1;
    localparam logic [2:0] PAD_SFC        = 3'd2;
    localparam logic [2:0] PAD_CYBER_DIG  = 3'd3;
    localparam logic [2:0] PAD_CYBER_ANA  = 3'd4;

    localparam logic [2:0] REG_PORT0_TYPE  = 3'd0;
    localparam logic [2:0] REG_PORT1_TYPE  = 3'd1;
    localparam logic [2:0] REG_SWAP_PORTS  = 3'd2;
    localparam logic [2:0] REG_KEY_ENABLE  = 3'd3;
    localparam logic [2:0] REG_KEY_SECOND  = 3'd4;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    typedef struct packed {
        logic       force_idle;
        logic [7:0] xor_mask;
    } rd_fmt_t;

    typedef struct packed {
        logic [2:0] port0_type;
        logic [2:0] port1_type;
        logic       swap_ports;
        logic       key_enable;
        logic       key_second;
    } cfg_t;

endpackage

`default_nettype wire

// ----- src/joystick_port_with_analog_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Two-port joystick interface with a sequenced analog pad.
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. command selects read (returns one byte), write of the port
// control byte, or load of one of twelve controller bytes per port. Writes
// and loads give no result and leave busy low, so one may follow every cycle.
// A read raises busy for one cycle while the controller byte RAM (24 x 8,
// one synchronous read port) returns its data; read_data is registered from
// the RAM output while busy is high and shows with read_valid for exactly one cycle.
// No command is taken while busy is high, so reads cannot come back to back.
// The receiver cannot stall: read_valid is a single-cycle strobe.
//
// Configuration: APB registers at byte addresses 0,4,8,12,16 hold the pad
// type of port 0 and port 1, port swap, key XOR enable and key port select.
// Writes are single-cycle on the access phase; pready is tied high.
//
// Reset: all controller bytes read as 0xff (per-entry valid bits), control
// bytes and analog slots clear, slot latency reloads, registers clear.

module joystick_port_with_analog_sequencer
    import jsq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // command channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic        port,
    input  wire logic [7:0]  data,
    input  wire logic [3:0]  byte_index,
    input  wire logic [7:0]  key_bits,
    // result
    output logic             read_valid,
    output logic [7:0]       read_data
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       cfg_wr;

    logic       accept;
    logic       busy_reg;
    rd_fmt_t    fmt;
    rd_fmt_t    fmt_reg;
    mem_req_t   mem_req;
    logic [7:0] mem_rdata;
    logic [7:0] read_data_reg;
    logic [7:0] read_data_next;
    logic       read_valid_reg;

    // ---------------- APB register file ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_PORT0_TYPE: cfg_next.port0_type = pwdata[2:0];
                REG_PORT1_TYPE: cfg_next.port1_type = pwdata[2:0];
                REG_SWAP_PORTS: cfg_next.swap_ports = pwdata[0];
                REG_KEY_ENABLE: cfg_next.key_enable = pwdata[0];
                REG_KEY_SECOND: cfg_next.key_second = pwdata[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PORT0_TYPE: prdata = {29'd0, cfg_reg.port0_type};
            REG_PORT1_TYPE: prdata = {29'd0, cfg_reg.port1_type};
            REG_SWAP_PORTS: prdata = {31'd0, cfg_reg.swap_ports};
            REG_KEY_ENABLE: prdata = {31'd0, cfg_reg.key_enable};
            REG_KEY_SECOND: prdata = {31'd0, cfg_reg.key_second};
            default:        prdata = '0;
        endcase
    end

    // ---------------- command path ----------------
    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    // per-port state and RAM address decode, updated at accept
    jsq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .command    (command),
        .port       (port),
        .data       (data),
        .byte_index (byte_index),
        .key_bits   (key_bits),
        .cfg        (cfg_reg),
        .mem_req    (mem_req),
        .fmt        (fmt)
    );

    jsq_padram u_padram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // RAM data lands during the busy cycle; format and register it
    assign read_data_next = fmt_reg.force_idle ? BYTE_IDLE : (mem_rdata ^ fmt_reg.xor_mask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= '0;
            busy_reg       <= 1'b0;
            read_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            busy_reg       <= accept && (command == CMD_READ);
            read_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fmt_reg <= fmt;
        end
        if (busy_reg)
        begin
            read_data_reg <= read_data_next;
        end
    end

    assign read_valid = read_valid_reg;
    assign read_data  = read_data_reg;

endmodule

`default_nettype wire

// ----- src/jsq_padram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module jsq_padram
    import jsq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mem_req_t req,
    output logic [7:0]    rdata
);

    logic [7:0]           mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [MEM_DEPTH-1:0] valid_next;
    logic [7:0]           rdata_reg;
    logic                 hit_reg;
    logic                 hit_next;

    // entries never loaded read as idle (all buttons released)
    always_comb
    begin
        valid_next = valid_reg;
        hit_next   = hit_reg;
        if (req.wr_en)
        begin
            valid_next[req.addr] = 1'b1;
        end
        if (req.rd_en)
        begin
            hit_next = valid_reg[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = hit_reg ? rdata_reg : BYTE_IDLE;

endmodule

`default_nettype wire

// ----- src/jsq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module jsq_ctrl
    import jsq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [1:0] command,
    input  wire logic       port,
    input  wire logic [7:0] data,
    input  wire logic [3:0] byte_index,
    input  wire logic [7:0] key_bits,
    input  wire cfg_t       cfg,
    output mem_req_t        mem_req,
    output rd_fmt_t         fmt
);

    logic [7:0] ctrl_reg [PORTS];
    logic [7:0] ctrl_next [PORTS];
    logic [3:0] slot_reg [PORTS];
    logic [3:0] slot_next [PORTS];
    logic [7:0] lat_reg [PORTS];
    logic [7:0] lat_next [PORTS];

    logic [2:0]        pad_type;
    logic [7:0]        ctl;
    logic [3:0]        slot;
    logic [7:0]        lat_dec;
    logic [MEM_AW-1:0] base;
    logic              in_range;
    logic              key_port;

    assign pad_type = port ? cfg.port1_type : cfg.port0_type;
    assign ctl      = ctrl_reg[port];
    assign slot     = slot_reg[port];
    assign lat_dec  = lat_reg[port] - 8'd1;
    assign base     = port ? PORT1_BASE : '0;
    assign in_range = (slot != 4'd0) && (slot <= SLOT_LAST);
    assign key_port = cfg.key_second ? port : !port;

    always_comb
    begin
        mem_req        = '0;
        fmt.force_idle = 1'b1;
        fmt.xor_mask   = '0;
        ctrl_next      = ctrl_reg;
        slot_next      = slot_reg;
        lat_next       = lat_reg;
        case (command)
            CMD_READ:
            begin
                case (pad_type)
                    PAD_CYBER_ANA:
                    begin
                        mem_req.rd_en  = accept && in_range;
                        mem_req.addr   = base + MEM_AW'(slot - 4'd1);
                        fmt.force_idle = !in_range;
                        // slot holds at the end; latency then keeps wrapping
                        if (accept)
                        begin
                            if ((lat_dec == 8'd0) && (slot < SLOT_END))
                            begin
                                slot_next[port] = slot + 4'd1;
                                lat_next[port]  = LATENCY;
                            end
                            else
                            begin
                                lat_next[port] = lat_dec;
                            end
                        end
                    end
                    PAD_MD, PAD_SFC, PAD_CYBER_DIG:
                    begin
                        mem_req.rd_en  = accept;
                        mem_req.addr   = base + ((ctl == BYTE_IDLE) ? MEM_AW'(1) : '0);
                        fmt.force_idle = 1'b0;
                    end
                    PAD_TWO_BUTTON:
                    begin
                        mem_req.rd_en  = accept;
                        mem_req.addr   = (port ^ cfg.swap_ports) ? PORT1_BASE : '0;
                        fmt.force_idle = (ctl == BYTE_IDLE);
                        fmt.xor_mask   = (cfg.key_enable && key_port) ? key_bits : '0;
                    end
                    default:
                    begin
                        fmt.force_idle = 1'b1;
                    end
                endcase
            end
            CMD_WRITE:
            begin
                if (accept && (pad_type <= PAD_CYBER_ANA))
                begin
                    ctrl_next[port] = data;
                    if ((pad_type == PAD_CYBER_ANA) && (data == 8'd0) && (ctl == BYTE_IDLE))
                    begin
                        slot_next[port] = 4'd0;
                        lat_next[port]  = LATENCY;
                    end
                end
            end
            CMD_LOAD:
            begin
                mem_req.wr_en = accept && (byte_index < 4'(BYTES_PER_PORT));
                mem_req.addr  = base + MEM_AW'(byte_index);
                mem_req.wdata = data;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORTS; i++)
            begin
                ctrl_reg[i] <= '0;
                slot_reg[i] <= '0;
                lat_reg[i]  <= LATENCY;
            end
        end
        else
        begin
            ctrl_reg <= ctrl_next;
            slot_reg <= slot_next;
            lat_reg  <= lat_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/jsq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module jsq_checker
    import jsq_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  command,
    input wire logic        read_valid
);

    logic rd_take;
    logic other_take;

    assign rd_take    = rst_n && start && !busy && (command == CMD_READ);
    assign other_take = rst_n && start && !busy && (command != CMD_READ);

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        rd_take |-> ##2 read_valid)
        else $error("read transaction gave no result");

    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        read_valid |-> $past(rd_take, 2))
        else $error("result without a read transaction");

    a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_no_busy_other: assert property (@(posedge clk) disable iff (!rst_n)
        other_take |=> !busy)
        else $error("write or load raised busy");

endmodule

bind joystick_port_with_analog_sequencer jsq_checker u_jsq_checker (.*);

`default_nettype wire

// ----- tb/sv/joystick_port_with_analog_sequencer_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the two-port joystick block.
// A scoreboard class keeps its own copy of the controller bytes, control bytes,
// analog slot state and the five config registers, predicts the byte each read
// transaction returns, and checks read_data strobes in order against it.

module joystick_port_with_analog_sequencer_tb;
    import jsq_pkg::*;

    // command code 3 is not decoded by the block; it must be ignored
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT = 100000;
    localparam int DRAIN_TAIL  = 4;
    localparam int PHASE_ITEMS = 30;
    localparam int NUM_PHASES  = 9;

    // ------------------------------------------------------------------
    // Scoreboard: mirror of the block state plus queue of predicted bytes
    // ------------------------------------------------------------------
    class joy_port_scoreboard;
        logic [7:0] pad_byte [PORTS][BYTES_PER_PORT];
        logic [7:0] ctl_byte [PORTS];
        logic [3:0] slot [PORTS];
        logic [7:0] slot_count [PORTS];
        logic [2:0] pad_type [PORTS];
        logic       swap;
        logic       key_en;
        logic       key_second;
        logic [7:0] read_bytes_q [$];
        int         errors;

        function new();
            for (int p = 0; p < PORTS; p++) begin
                for (int i = 0; i < BYTES_PER_PORT; i++)
                begin
                    pad_byte[p][i] = BYTE_IDLE;
                end
                ctl_byte[p]   = 8'h00;
                slot[p]       = 4'd0;
                slot_count[p] = LATENCY;
                pad_type[p]   = PAD_TWO_BUTTON;
            end
            swap       = 1'b0;
            key_en     = 1'b0;
            key_second = 1'b0;
            errors     = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void set_reg(input logic [2:0] idx, input logic [31:0] v);
            case (idx)
                REG_PORT0_TYPE: pad_type[0] = v[2:0];
                REG_PORT1_TYPE: pad_type[1] = v[2:0];
                REG_SWAP_PORTS: swap        = v[0];
                REG_KEY_ENABLE: key_en      = v[0];
                REG_KEY_SECOND: key_second  = v[0];
                default: ;
            endcase
        endfunction

        // Analog pad: slot 0 idles high, slots 1..12 give bytes 0..11, each slot
        // held for LATENCY reads. Past the last slot the counter free-runs.
        function logic [7:0] analog_byte(input int p);
            logic [7:0] r;
            logic [3:0] s;
            r = BYTE_IDLE;
            s = slot[p];
            if (s >= 4'd1 && s <= SLOT_LAST)
                r = pad_byte[p][s - 4'd1];
            slot_count[p] = slot_count[p] - 8'd1;
            if (slot_count[p] == 8'd0)
            begin
                if (s >= SLOT_END)
                    r = BYTE_IDLE;
                else
                begin
                    slot[p]       = s + 4'd1;
                    slot_count[p] = LATENCY;
                end
            end
            return r;
        endfunction

        function logic [7:0] predict_read(input int p, input logic [7:0] keys);
            logic [7:0] r;
            case (pad_type[p])
                PAD_CYBER_ANA: r = analog_byte(p);
                PAD_MD, PAD_SFC, PAD_CYBER_DIG:
                    r = (ctl_byte[p] == BYTE_IDLE) ? pad_byte[p][1] : pad_byte[p][0];
                PAD_TWO_BUTTON:
                begin
                    r = pad_byte[(p ^ int'(swap)) & 1][0];
                    if (key_en && (key_second ? (p == 1) : (p == 0)))
                        r ^= keys;
                    if (ctl_byte[p] == BYTE_IDLE)
                        r = BYTE_IDLE;
                end
                default: r = BYTE_IDLE;     // unused pad types
            endcase
            return r;
        endfunction

        function void note_transaction(input logic [1:0] cmd, input logic prt,
                                       input logic [7:0] d, input logic [3:0] idx,
                                       input logic [7:0] keys);
            int p;
            p = int'(prt);
            case (cmd)
                CMD_READ: read_bytes_q.push_back(predict_read(p, keys));
                CMD_WRITE:
                begin
                    if (pad_type[p] == PAD_CYBER_ANA)
                    begin
                        // 0xff then 0 restarts the analog sequence
                        if (d == 8'h00 && ctl_byte[p] == BYTE_IDLE)
                        begin
                            slot[p]       = 4'd0;
                            slot_count[p] = LATENCY;
                        end
                        ctl_byte[p] = d;
                    end
                    else if (pad_type[p] <= PAD_CYBER_DIG)
                        ctl_byte[p] = d;
                end
                CMD_LOAD:
                begin
                    if (idx < BYTES_PER_PORT)
                        pad_byte[p][idx] = d;
                end
                default: ;
            endcase
        endfunction

        task check_read(input logic [7:0] got);
            logic [7:0] want;
            if (read_bytes_q.size() == 0)
                report($sformatf("read byte %02h with no read outstanding", got));
            else
            begin
                want = read_bytes_q.pop_front();
                if (got !== want)
                    report($sformatf("read_data %02h, predicted %02h", got, want));
            end
        endtask

        function int pending();
            return read_bytes_q.size();
        endfunction

        task finish_check();
            if (read_bytes_q.size() != 0)
                report($sformatf("%0d reads never returned", read_bytes_q.size()));
        endtask
    endclass

    // ------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [4:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start      = 1'b0;
    logic        busy;
    logic [1:0]  command    = CMD_READ;
    logic        port       = 1'b0;
    logic [7:0]  data       = '0;
    logic [3:0]  byte_index = '0;
    logic [7:0]  key_bits   = '0;
    logic        read_valid;
    logic [7:0]  read_data;

    joy_port_scoreboard sb;
    int   sent_count;
    int   cycle_count = 0;
    cfg_t phase_cfg [NUM_PHASES];

    joystick_port_with_analog_sequencer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .port       (port),
        .data       (data),
        .byte_index (byte_index),
        .key_bits   (key_bits),
        .read_valid (read_valid),
        .read_data  (read_data)
    );

    always #5 clk = ~clk;

    // Hard stop in case a handshake never completes
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: strobe only, no back-pressure possible
    always @(posedge clk)
    begin
        if (rst_n && read_valid)
            sb.check_read(read_data);
    end

    // ------------------------------------------------------------------
    // Drivers. Every task starts and ends right after a rising edge.
    // ------------------------------------------------------------------

    // APB write: setup, then access; register updates on the access edge.
    // psel then drops for an idle phase so the next write starts on a later edge.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    // One command transaction; start is left high so back-to-back items
    // do not drop it between them.
    task automatic send(input logic [1:0] c, input logic p, input logic [7:0] d,
                        input logic [3:0] idx, input logic [7:0] k);
        start      <= 1'b1;
        command    <= c;
        port       <= p;
        data       <= d;
        byte_index <= idx;
        key_bits   <= k;
        do
            @(posedge clk);
        while (busy);
        sb.note_transaction(c, p, d, idx, k);
        if (c != CMD_UNUSED)
            sent_count++;
    endtask

    task automatic maybe_idle(input bit gaps);
        if (gaps && $urandom_range(0, 4) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Hold off until every read has come back, then wait out DRAIN_TAIL for
    // writes/loads still settling.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic apply_config(input cfg_t c);
        drain();
        reg_write(REG_PORT0_TYPE, 32'(c.port0_type));
        reg_write(REG_PORT1_TYPE, 32'(c.port1_type));
        reg_write(REG_SWAP_PORTS, 32'(c.swap_ports));
        reg_write(REG_KEY_ENABLE, 32'(c.key_enable));
        reg_write(REG_KEY_SECOND, 32'(c.key_second));
    endtask

    // Restart handshake (0xff then 0) followed by a run of reads on one port.
    // About 42 reads walk the whole sequence and past its end.
    task automatic analog_walk(input logic p, input int reads, input bit gaps);
        send(CMD_WRITE, p, BYTE_IDLE, 4'($urandom), 8'($urandom));
        maybe_idle(gaps);
        send(CMD_WRITE, p, 8'h00, 4'($urandom), 8'($urandom));
        repeat (reads)
        begin
            maybe_idle(gaps);
            send(CMD_READ, p, 8'($urandom), 4'($urandom), 8'($urandom));
        end
    endtask

    task automatic random_item(input bit gaps);
        int   pick;
        logic p;
        logic [7:0] ctl;
        logic [3:0] idx;
        pick = $urandom_range(0, 99);
        p    = 1'($urandom_range(0, 1));
        // control writes favor 0x00 and 0xff, which steer the pad decode
        ctl  = ($urandom_range(0, 2) == 0) ? 8'h00 :
               ($urandom_range(0, 1) == 0) ? BYTE_IDLE : 8'($urandom);
        // out-of-range load indexes now and then
        idx  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15)) :
                                             4'($urandom_range(0, 11));
        if (pick < 40)
            send(CMD_READ, p, 8'($urandom), 4'($urandom), 8'($urandom));
        else if (pick < 55)
            send(CMD_WRITE, p, ctl, 4'($urandom), 8'($urandom));
        else if (pick < 78)
            send(CMD_LOAD, p, 8'($urandom), idx, 8'($urandom));
        else if (pick < 82)
            send(CMD_UNUSED, p, 8'($urandom), 4'($urandom), 8'($urandom));
        else if (pick < 84)
            drain();
        else
            analog_walk(p, $urandom_range(1, 24), gaps);
        maybe_idle(gaps);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        sb = new();
        sent_count = 0;

        // port0, port1, swap, key enable, key on second port
        phase_cfg[0] = '{PAD_TWO_BUTTON, PAD_TWO_BUTTON, 1'b1, 1'b1, 1'b0};
        phase_cfg[1] = '{PAD_TWO_BUTTON, PAD_TWO_BUTTON, 1'b0, 1'b1, 1'b1};
        phase_cfg[2] = '{PAD_CYBER_ANA, PAD_CYBER_ANA, 1'b0, 1'b0, 1'b0};
        phase_cfg[3] = '{PAD_MD, PAD_SFC, 1'b1, 1'b0, 1'b1};
        phase_cfg[4] = '{PAD_CYBER_DIG, PAD_CYBER_ANA, 1'b0, 1'b1, 1'b0};
        phase_cfg[5] = '{PAD_CYBER_ANA, PAD_TWO_BUTTON, 1'b1, 1'b1, 1'b1};
        phase_cfg[6] = '{3'd5, 3'd7, 1'b0, 1'b0, 1'b0};    // undecoded pad types
        phase_cfg[7] = '{3'd6, PAD_CYBER_ANA, 1'b1, 1'b0, 1'b0};
        phase_cfg[8] = cfg_t'(9'($urandom));               // last phase: no gaps

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset contents, loads incl. out-of-range index, unused
        // command, control 0xff forcing idle on a two-button pad, key XOR.
        send(CMD_READ, 1'b0, 8'h00, 4'd0, 8'hff);
        send(CMD_READ, 1'b1, 8'h00, 4'd0, 8'h00);
        send(CMD_LOAD, 1'b0, 8'h00, 4'd0, 8'h00);
        send(CMD_LOAD, 1'b0, 8'h5a, 4'd11, 8'h00);
        send(CMD_LOAD, 1'b1, 8'ha5, 4'd0, 8'h00);
        send(CMD_LOAD, 1'b0, 8'h12, 4'd12, 8'h00);
        send(CMD_LOAD, 1'b1, 8'h34, 4'd15, 8'h00);
        send(CMD_UNUSED, 1'b1, 8'hff, 4'd15, 8'hff);
        send(CMD_READ, 1'b0, 8'hff, 4'd15, 8'hff);
        send(CMD_READ, 1'b1, 8'hff, 4'd15, 8'hff);
        send(CMD_WRITE, 1'b0, BYTE_IDLE, 4'd0, 8'h00);
        send(CMD_READ, 1'b0, 8'h00, 4'd0, 8'h00);
        send(CMD_WRITE, 1'b0, 8'h00, 4'd0, 8'h00);
        send(CMD_READ, 1'b0, 8'h00, 4'd0, 8'h00);
        drain();
        reg_write(REG_SWAP_PORTS, 32'd1);
        reg_write(REG_KEY_ENABLE, 32'd1);
        send(CMD_READ, 1'b0, 8'h00, 4'd0, 8'hff);
        send(CMD_READ, 1'b1, 8'h00, 4'd0, 8'h0f);
        drain();
        reg_write(REG_KEY_SECOND, 32'd1);
        send(CMD_READ, 1'b0, 8'h00, 4'd0, 8'hff);
        send(CMD_READ, 1'b1, 8'h00, 4'd0, 8'hff);
        send(CMD_WRITE, 1'b1, BYTE_IDLE, 4'd0, 8'h00);
        send(CMD_READ, 1'b1, 8'h00, 4'd0, 8'h3c);

        // Random phases, config changed only with nothing in flight
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            apply_config(phase_cfg[ph]);
            sent_count = 0;
            if (phase_cfg[ph].port0_type == PAD_CYBER_ANA && ph == 2)
            begin
                // full sequence on both ports, through the end and the
                // free-running counter past it
                analog_walk(1'b0, 45, 1'b1);
                analog_walk(1'b1, 44, 1'b0);
            end
            while (sent_count < PHASE_ITEMS)
                random_item(ph != NUM_PHASES - 1);
        end

        drain();
        sb.finish_check();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/jsq_pkg.sv
src/jsq_padram.sv
src/jsq_ctrl.sv
src/joystick_port_with_analog_sequencer.sv
src/jsq_checker.sv
tb/sv/joystick_port_with_analog_sequencer_tb.sv
